// ===== design/mpool_pkg.sv =====
// ============================================================================
// mpool_pkg
// Shared constants for the 3x3 stride-2 max pooling block: configuration
// register indexes, register field widths and the fixed row limit.
// ============================================================================
`default_nettype none

package mpool_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd2;

    localparam int CH_REG_W  = 6;
    localparam int ROW_REG_W = 13;
    localparam int COL_REG_W = 10;

    localparam int ROW_LIMIT = 4096;
    localparam int ROW_W     = 12;

endpackage

`default_nettype wire

// ===== design/max_pool_3x3_stride2.sv =====
// ============================================================================
// max_pool_3x3_stride2
// Streaming 3x3 max pool, stride 2, padding 1, over an NHWC raster stream.
// ============================================================================
// The block takes one channel element per clock unless o_in_stall holds it,
// and gives one pooled element per channel when the last existing tap of its
// 3x3 window arrives. The sustained rate is one request per cycle while no
// result is blocked at the output: at accept, the horizontal partial
// (per channel) and the vertical partial (per output column and channel) are
// read from two synchronous memories, and in the execute stage the max is
// formed, written back and loaded into the output register. Back-to-back
// accesses to the same entry are forwarded from the write-back. No clearing
// pass is needed after reset. A write to any of the three configuration
// registers returns the position to the start of a frame.
`default_nettype none

module max_pool_3x3_stride2 #(
    parameter int MAX_CHANNELS = 32,
    parameter int MAX_WIDTH    = 512,
    parameter int DATA_BITS    = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire  signed [DATA_BITS-1:0]         i_sample_value,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic signed [DATA_BITS-1:0]         o_pooled_value,
    output logic                                o_frame_last,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [mpool_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [mpool_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mpool_pkg::*;

    localparam int CH_AW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int OW_W    = COL_W - 1;
    localparam int VA_W    = OW_W + CH_AW;
    localparam int V_DEPTH = 2 ** VA_W;
    localparam int H_DEPTH = 2 ** CH_AW;

    function automatic logic signed [DATA_BITS-1:0] f_max(
        input logic signed [DATA_BITS-1:0] a,
        input logic signed [DATA_BITS-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    // configuration, kept as last index values
    logic [CH_AW-1:0]  r_ch_last;
    logic [COL_W-1:0]  r_col_last;
    logic [ROW_W-1:0]  r_row_last;
    logic [CH_AW-1:0]  n_ch_last;
    logic [COL_W-1:0]  n_col_last;
    logic [ROW_W-1:0]  n_row_last;
    logic [31:0]       cfg_ch32;
    logic [31:0]       cfg_row32;
    logic [31:0]       cfg_col32;

    // position counters
    logic [CH_AW-1:0]  r_ch;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [CH_AW-1:0]  n_ch;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;

    logic              cfg_we;
    logic              in_acc;
    logic              last_ch;
    logic              last_col;
    logic              last_row;
    logic [VA_W-1:0]   vaddr;

    // memories
    logic signed [DATA_BITS-1:0] r_hmem [H_DEPTH];
    logic signed [DATA_BITS-1:0] r_vmem [V_DEPTH];
    logic signed [DATA_BITS-1:0] r_h_rdata;
    logic signed [DATA_BITS-1:0] r_v_rdata;

    // execute stage
    logic                        r_s1_valid;
    logic [CH_AW-1:0]            r_s1_ch;
    logic [VA_W-1:0]             r_s1_vaddr;
    logic                        r_s1_col_odd;
    logic                        r_s1_col_zero;
    logic                        r_s1_last_col;
    logic                        r_s1_row_odd;
    logic                        r_s1_row_zero;
    logic                        r_s1_last_row;
    logic                        r_s1_last_ch;
    logic signed [DATA_BITS-1:0] r_s1_x;

    logic                        r_fwd_h;
    logic                        r_fwd_v;
    logic signed [DATA_BITS-1:0] r_fwd_h_data;
    logic signed [DATA_BITS-1:0] r_fwd_v_data;

    logic signed [DATA_BITS-1:0] h_old;
    logic signed [DATA_BITS-1:0] h_even;
    logic signed [DATA_BITS-1:0] h_wdata;
    logic signed [DATA_BITS-1:0] hm;
    logic signed [DATA_BITS-1:0] v_old;
    logic signed [DATA_BITS-1:0] v_even;
    logic signed [DATA_BITS-1:0] v_wdata;
    logic signed [DATA_BITS-1:0] res_val;
    logic                        v_active;
    logic                        s1_res;
    logic                        s1_go;

    logic                        r_out_valid;
    logic signed [DATA_BITS-1:0] r_out_value;
    logic                        r_out_last;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        cfg_ch32  = 32'(i_cfg_data[CH_REG_W-1:0]);
        cfg_row32 = 32'(i_cfg_data[ROW_REG_W-1:0]);
        cfg_col32 = 32'(i_cfg_data[COL_REG_W-1:0]);
        if (cfg_ch32 == 32'd0) begin
            n_ch_last = '0;
        end else if (cfg_ch32 > 32'(MAX_CHANNELS)) begin
            n_ch_last = CH_AW'(MAX_CHANNELS - 1);
        end else begin
            n_ch_last = CH_AW'(cfg_ch32 - 32'd1);
        end
        if (cfg_row32 == 32'd0) begin
            n_row_last = '0;
        end else if (cfg_row32 > 32'(ROW_LIMIT)) begin
            n_row_last = ROW_W'(ROW_LIMIT - 1);
        end else begin
            n_row_last = ROW_W'(cfg_row32 - 32'd1);
        end
        if (cfg_col32 == 32'd0) begin
            n_col_last = '0;
        end else if (cfg_col32 > 32'(MAX_WIDTH)) begin
            n_col_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            n_col_last = COL_W'(cfg_col32 - 32'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_last  <= '0;
            r_row_last <= ROW_W'(1);
            r_col_last <= COL_W'(1);
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_CHANNEL_COUNT: r_ch_last  <= n_ch_last;
                CFG_IMAGE_HEIGHT:  r_row_last <= n_row_last;
                CFG_IMAGE_WIDTH:   r_col_last <= n_col_last;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // position
    // ------------------------------------------------------------------
    assign in_acc   = i_in_valid && !o_in_stall;
    assign last_ch  = (r_ch == r_ch_last);
    assign last_col = (r_col == r_col_last);
    assign last_row = (r_row == r_row_last);
    assign vaddr    = {r_col[COL_W-1:1], r_ch};

    always_comb begin
        n_ch  = r_ch;
        n_col = r_col;
        n_row = r_row;
        if (last_ch) begin
            n_ch = '0;
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end else begin
            n_ch = r_ch + CH_AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch  <= '0;
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_we && (i_cfg_index == CFG_CHANNEL_COUNT ||
                                i_cfg_index == CFG_IMAGE_HEIGHT ||
                                i_cfg_index == CFG_IMAGE_WIDTH)) begin
            r_ch  <= '0;
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_ch  <= n_ch;
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // partial stores: read at accept, write back from execute
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_hmem[r_s1_ch] <= h_wdata;
        end
        if (in_acc) begin
            r_h_rdata <= r_hmem[r_ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && v_active) begin
            r_vmem[r_s1_vaddr] <= v_wdata;
        end
        if (in_acc) begin
            r_v_rdata <= r_vmem[vaddr];
        end
    end

    // ------------------------------------------------------------------
    // execute stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_h    <= 1'b0;
            r_fwd_v    <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
            r_fwd_h    <= s1_go && (r_s1_ch == r_ch);
            r_fwd_v    <= s1_go && v_active && (r_s1_vaddr == vaddr);
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
            r_fwd_h    <= 1'b0;
            r_fwd_v    <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ch       <= r_ch;
            r_s1_vaddr    <= vaddr;
            r_s1_col_odd  <= r_col[0];
            r_s1_col_zero <= (r_col == '0);
            r_s1_last_col <= last_col;
            r_s1_row_odd  <= r_row[0];
            r_s1_row_zero <= (r_row == '0);
            r_s1_last_row <= last_row;
            r_s1_last_ch  <= last_ch;
            r_s1_x        <= i_sample_value;
            r_fwd_h_data  <= h_wdata;
            r_fwd_v_data  <= v_wdata;
        end
    end

    always_comb begin
        h_old    = r_fwd_h ? r_fwd_h_data : r_h_rdata;
        h_even   = r_s1_col_zero ? r_s1_x : f_max(h_old, r_s1_x);
        h_wdata  = r_s1_col_odd ? r_s1_x : h_even;
        hm       = r_s1_col_odd ? f_max(h_old, r_s1_x) : h_even;
        v_active = r_s1_col_odd || r_s1_last_col;
        v_old    = r_fwd_v ? r_fwd_v_data : r_v_rdata;
        v_even   = r_s1_row_zero ? hm : f_max(v_old, hm);
        v_wdata  = r_s1_row_odd ? hm : v_even;
        res_val  = r_s1_row_odd ? f_max(v_old, hm) : v_even;
        s1_res   = v_active && (r_s1_row_odd || r_s1_last_row);
    end

    assign s1_go      = r_s1_valid && (!s1_res || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_go;

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && s1_res) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_res) begin
            r_out_value <= res_val;
            r_out_last  <= r_s1_last_row && r_s1_last_col && r_s1_last_ch;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pooled_value = r_out_value;
    assign o_frame_last   = r_out_last;

`ifndef SYNTHESIS
    a_stall_only_on_blocked_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && s1_res && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted request did not reach execute stage");

    a_position_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ch <= r_ch_last) && (r_col <= r_col_last) && (r_row <= r_row_last))
        else $error("position counter beyond configured extent");

    a_fwd_needs_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fwd_h || r_fwd_v) |-> r_s1_valid)
        else $error("forwarding flag set with empty execute stage");

    a_result_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && s1_res) |=> o_out_valid)
        else $error("completed result not presented");
`endif

endmodule

`default_nettype wire

// ===== verif/max_pool_3x3_stride2_test.sv =====
// ----------------------------------------------------------------------------
// max_pool_3x3_stride2_test
// Self-checking bench for the streaming 3x3 stride-2 max pool. Samples go in
// on a valid/stall channel with random gaps, and pooled results come out under
// random back-pressure. A predictor inside the bench tracks the frame position
// and both partial-max stores, and each pooled result is checked in order.
// Directed tests cover the default setting, images one row or one column in
// size, register clamping and the unused register index. They are followed by
// the widest row, the most channels and random settings that end in whole or
// broken frames.
// ----------------------------------------------------------------------------
module max_pool_3x3_stride2_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mpool_pkg::*;

    localparam int SAMPLE_W    = 16;
    localparam int CH_MAX      = 32;
    localparam int WIDTH_MAX   = 512;
    localparam int OUT_COLS    = (WIDTH_MAX + 1) / 2;
    localparam int ITEM_TARGET = 1550;
    localparam int IDLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 1000000;

    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic                       frame_end;
    } pooled_t;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic signed [SAMPLE_W-1:0]      i_sample_value;
    logic                            o_out_valid;
    logic                            i_out_stall;
    logic signed [SAMPLE_W-1:0]      o_pooled_value;
    logic                            o_frame_last;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [CFG_IDX_W-1:0]            i_cfg_index;
    logic [CFG_DATA_W-1:0]           i_cfg_data;

    max_pool_3x3_stride2 #(
        .MAX_CHANNELS (CH_MAX),
        .MAX_WIDTH    (WIDTH_MAX),
        .DATA_BITS    (SAMPLE_W)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_value (i_sample_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pooled_value (o_pooled_value),
        .o_frame_last   (o_frame_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    logic [CH_REG_W-1:0]        channel_reg;
    logic [ROW_REG_W-1:0]       height_reg;
    logic [COL_REG_W-1:0]       width_reg;
    int                         pos_channel;
    int                         pos_col;
    int                         pos_row;
    logic signed [SAMPLE_W-1:0] row_partial [CH_MAX];
    logic signed [SAMPLE_W-1:0] col_partial [OUT_COLS * CH_MAX];

    pooled_t pooled_expected [$];

    int  samples_sent;
    int  pooled_checked;
    int  frames_checked;
    int  setting_count;
    int  mismatch_count;
    int  cycle_count;
    bit  in_gaps_on;
    bit  out_stall_on;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 pooled_expected.size());
        $display("max_pool_3x3_stride2_test: errors");
        $finish;
    end

    function automatic int clamp_to(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] smax(input logic signed [SAMPLE_W-1:0] a,
                                                        input logic signed [SAMPLE_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic int frame_size();
        return clamp_to(channel_reg, CH_MAX) * clamp_to(height_reg, ROW_LIMIT)
               * clamp_to(width_reg, WIDTH_MAX);
    endfunction

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            case ($urandom_range(0, 3))
                0: return 16'sh7fff;
                1: return 16'sh8000;
                2: return 16'sh0000;
                default: return 16'shffff;
            endcase
        end
        if (roll < 3) return SAMPLE_W'($urandom_range(0, 7)) - 16'sd4;
        return SAMPLE_W'($urandom);
    endfunction

    task automatic pool_window_update(input logic signed [SAMPLE_W-1:0] x);
        int nc;
        int nh;
        int nw;
        int ch;
        int c;
        int r;
        int idx;
        bit last_col;
        bit last_row;
        logic signed [SAMPLE_W-1:0] hmax;
        pooled_t e;
        nc = clamp_to(channel_reg, CH_MAX);
        nh = clamp_to(height_reg, ROW_LIMIT);
        nw = clamp_to(width_reg, WIDTH_MAX);
        ch = (pos_channel >= nc) ? 0 : pos_channel;
        c  = (pos_col >= nw) ? 0 : pos_col;
        r  = (pos_row >= nh) ? 0 : pos_row;
        last_col = (c + 1 == nw);
        last_row = (r + 1 == nh);
        if (c % 2 == 0) begin
            row_partial[ch] = (c == 0) ? x : smax(row_partial[ch], x);
        end
        if (c % 2 == 1 || last_col) begin
            hmax = smax(row_partial[ch], x);
            idx = ((c / 2) % OUT_COLS) * CH_MAX + ch;
            if (c % 2 == 1) row_partial[ch] = x;
            if (r % 2 == 0) begin
                col_partial[idx] = (r == 0) ? hmax : smax(col_partial[idx], hmax);
                if (last_row) begin
                    e.value = col_partial[idx];
                    e.frame_end = last_col && (ch + 1 == nc);
                    pooled_expected.push_back(e);
                end
            end else begin
                e.value = smax(col_partial[idx], hmax);
                e.frame_end = last_row && last_col && (ch + 1 == nc);
                pooled_expected.push_back(e);
                col_partial[idx] = hmax;
            end
        end
        ch++;
        if (ch >= nc) begin
            ch = 0;
            c++;
            if (c >= nw) begin
                c = 0;
                r++;
                if (r >= nh) r = 0;
            end
        end
        pos_channel = ch;
        pos_col = c;
        pos_row = r;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
        int gap;
        gap = in_gaps_on ? gap_len() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_sample_value <= v;
        do @(posedge i_clk); while (o_in_stall);
        pool_window_update(v);
        samples_sent++;
    endtask

    task automatic wait_pool_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pooled_expected.size() != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_CHANNEL_COUNT: channel_reg = data[CH_REG_W-1:0];
            CFG_IMAGE_HEIGHT:  height_reg = data[ROW_REG_W-1:0];
            CFG_IMAGE_WIDTH:   width_reg = data[COL_REG_W-1:0];
            default: ;
        endcase
        if (idx != CFG_NO_REG) begin
            pos_channel = 0;
            pos_col = 0;
            pos_row = 0;
        end
        setting_count++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int nch, input int nht, input int nwd);
        wait_pool_idle();
        write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(nch));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(nht));
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(nwd));
    endtask

    // Default setting is one channel, 2x2 image: one result per frame.
    task automatic test_reset_defaults();
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'shffff);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'shffff);
        send_sample(16'sh8000);
    endtask

    task automatic test_unit_extent();
        configure(1, 1, 3);
        repeat (3) send_sample(rand_sample());
        configure(1, 3, 1);
        repeat (3) send_sample(rand_sample());
    endtask

    task automatic test_register_clamp();
        wait_pool_idle();
        write_reg(CFG_CHANNEL_COUNT, 13'h1fc0);
        write_reg(CFG_IMAGE_HEIGHT, 13'h0000);
        write_reg(CFG_IMAGE_WIDTH, 13'h1c00);
        repeat (2) send_sample(rand_sample());
        wait_pool_idle();
        write_reg(CFG_CHANNEL_COUNT, 13'h1fff);
        write_reg(CFG_IMAGE_HEIGHT, 13'h1fff);
        write_reg(CFG_IMAGE_WIDTH, 13'h1fff);
        repeat (3) send_sample(rand_sample());
    endtask

    // The unused index must neither change a register nor restart the frame.
    task automatic test_unused_index();
        configure(1, 2, 2);
        repeat (2) send_sample(rand_sample());
        wait_pool_idle();
        write_reg(CFG_NO_REG, CFG_DATA_W'($urandom));
        repeat (2) send_sample(rand_sample());
    endtask

    task automatic test_wide_row();
        configure(1, 1, WIDTH_MAX);
        repeat (WIDTH_MAX) send_sample(rand_sample());
    endtask

    task automatic test_many_channels();
        configure(CH_MAX, 2, 2);
        repeat (4 * CH_MAX) send_sample(rand_sample());
    endtask

    task automatic test_random_settings();
        int roll;
        int size;
        int count;
        logic [CFG_DATA_W-1:0] data;
        while (samples_sent < ITEM_TARGET) begin
            wait_pool_idle();
            in_gaps_on = ($urandom_range(0, 3) != 0);
            out_stall_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) != 0) begin
                roll = $urandom_range(0, 19);
                data = CFG_DATA_W'($urandom);
                if (roll < 14) data[CH_REG_W-1:0] = CH_REG_W'($urandom_range(1, 4));
                else if (roll < 17) data[CH_REG_W-1:0] = CH_REG_W'($urandom_range(5, CH_MAX));
                else if (roll < 19) data[CH_REG_W-1:0] = CH_REG_W'($urandom_range(33, 63));
                else data[CH_REG_W-1:0] = '0;
                write_reg(CFG_CHANNEL_COUNT, data);
            end
            if ($urandom_range(0, 4) != 0) begin
                roll = $urandom_range(0, 19);
                if (roll < 16) data = CFG_DATA_W'($urandom_range(1, 7));
                else if (roll < 18) data = CFG_DATA_W'($urandom_range(8, 30));
                else if (roll < 19) data = CFG_DATA_W'($urandom_range(ROW_LIMIT + 1, 8191));
                else data = '0;
                write_reg(CFG_IMAGE_HEIGHT, data);
            end
            if ($urandom_range(0, 4) != 0) begin
                roll = $urandom_range(0, 19);
                data = CFG_DATA_W'($urandom);
                if (roll < 16) data[COL_REG_W-1:0] = COL_REG_W'($urandom_range(1, 8));
                else if (roll < 18) data[COL_REG_W-1:0] = COL_REG_W'($urandom_range(9, 40));
                else if (roll < 19) data[COL_REG_W-1:0] = COL_REG_W'($urandom_range(513, 1023));
                else data[COL_REG_W-1:0] = '0;
                write_reg(CFG_IMAGE_WIDTH, data);
            end
            if ($urandom_range(0, 9) == 0) write_reg(CFG_NO_REG, CFG_DATA_W'($urandom));
            size = frame_size();
            count = (size <= 240) ? size * $urandom_range(1, 3) : 0;
            if (size > 1 && (count == 0 || $urandom_range(0, 3) == 0)) begin
                count += $urandom_range(1, (size - 1 < 150) ? size - 1 : 150);
            end
            if (count > ITEM_TARGET - samples_sent) count = ITEM_TARGET - samples_sent;
            repeat (count) send_sample(rand_sample());
        end
    endtask

    initial begin : out_stall_gen
        int run;
        bit level;
        run = 0;
        level = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run == 0) begin
                level = out_stall_on && ($urandom_range(0, 2) == 0);
                if (!level) run = $urandom_range(1, 6);
                else if ($urandom_range(0, 99) < 85) run = $urandom_range(1, 3);
                else run = $urandom_range(8, 50);
            end
            run--;
            i_out_stall <= level;
        end
    end

    always @(posedge i_clk) begin : pooled_check
        pooled_t e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pooled_expected.size() == 0) begin
                $display("%0t: unexpected result value %0d frame_last %0b", $time,
                         o_pooled_value, o_frame_last);
                mismatch_count++;
            end else begin
                e = pooled_expected.pop_front();
                if (o_pooled_value !== e.value) begin
                    $display("%0t: pooled_value expected %0d actual %0d", $time, e.value,
                             o_pooled_value);
                    mismatch_count++;
                end
                if (o_frame_last !== e.frame_end) begin
                    $display("%0t: frame_last expected %0b actual %0b", $time, e.frame_end,
                             o_frame_last);
                    mismatch_count++;
                end
                pooled_checked++;
                if (e.frame_end) frames_checked++;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_sample_value = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_CHANNEL_COUNT;
        i_cfg_data = '0;
        channel_reg = CH_REG_W'(1);
        height_reg = ROW_REG_W'(2);
        width_reg = COL_REG_W'(2);
        pos_channel = 0;
        pos_col = 0;
        pos_row = 0;
        samples_sent = 0;
        pooled_checked = 0;
        frames_checked = 0;
        setting_count = 0;
        mismatch_count = 0;
        in_gaps_on = 1'b1;
        out_stall_on = 1'b1;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_unit_extent();
        test_register_clamp();
        test_unused_index();
        test_wide_row();
        test_many_channels();
        test_random_settings();

        wait_pool_idle();
        if (pooled_expected.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pooled_expected.size());
            mismatch_count++;
        end
        $display("sent %0d samples over %0d register writes", samples_sent, setting_count);
        $display("checked %0d pooled results, %0d frame ends, %0d mismatches",
                 pooled_checked, frames_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("max_pool_3x3_stride2_test: clean");
        end else begin
            $display("max_pool_3x3_stride2_test: errors");
        end
        $finish;
    end

endmodule
